// File: hw/rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 decoder with source positions.
`default_nettype none

package utf8d_pkg;

    localparam int LINE_W   = 20;
    localparam int COLUMN_W = 16;
    localparam int OFFSET_W = 24;
    localparam int CP_W     = 21;

    localparam logic [LINE_W-1:0]   LINE_MAX   = '1;
    localparam logic [COLUMN_W-1:0] COLUMN_MAX = '1;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFE;
    localparam logic [CP_W-1:0] NEWLINE_CP     = 21'h00000A;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_BAD_LEAD  = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_END  = 1'b1
    } req_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0]     codepoint;
        status_t             status;
        logic [LINE_W-1:0]   line_number;
        logic [COLUMN_W-1:0] column_number;
        logic [OFFSET_W-1:0] start_offset;
        logic                last_of_run;
    } cp_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/utf8_decode_with_position_core.sv
// Top level of the UTF-8 decoder that tags each codepoint with line, column and offset.
`default_nettype none

// Usage
// The byte channel (byte_valid, byte_stall, byte_item) carries one item per source
// byte, or an end-of-input request. The codepoint channel (cp_valid, cp_stall,
// cp_item) returns decoded items with their line, column and start offset.
// An item is taken at a rising edge where valid is high and stall is low.
// Each byte is decoded in the cycle it is accepted and its results are registered
// into a three-entry result queue whose entry 0 drives the output.
// One byte is accepted every cycle while results drain, so the sustained rate is
// one item per cycle, limited by the single output port of the queue: a byte that
// yields two results (a broken sequence followed by an ASCII or bad lead byte, or a
// flush before the end result) holds the output for both results in turn.
// When the receiver stalls, the queue keeps filling until fewer than two entries
// would be free, and byte_stall then rises until the receiver takes results.
// Reset empties the queue and returns the position to line 1, column 1, offset 0.
// After an end request, data bytes are accepted and dropped; every further end
// request repeats the end result.
module utf8_decode_with_position_core
    import utf8d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_item_t byte_item,
    output logic            cp_valid,
    input  wire logic       cp_stall,
    output cp_item_t        cp_item
);

    localparam int QUEUE_DEPTH = 3;

    // Decoder state.
    logic [1:0]          pending_reg, pending_next;
    logic [CP_W-1:0]     partial_reg, partial_next;
    logic [OFFSET_W-1:0] counter_reg, counter_next;
    logic [OFFSET_W-1:0] seq_start_reg, seq_start_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [COLUMN_W-1:0] column_reg, column_next;
    logic                ended_reg, ended_next;

    // Result queue; entry 0 drives the output.
    cp_item_t queue_reg [QUEUE_DEPTH];
    cp_item_t queue_next [QUEUE_DEPTH];
    logic [1:0] count_reg, count_next;

    logic       pop;
    logic       accept;
    logic [1:0] count_shifted;

    cp_item_t   res [2];
    logic [1:0] num_res;

    assign cp_valid = (count_reg != 2'd0);
    assign cp_item  = queue_reg[0];
    assign pop      = cp_valid && !cp_stall;

    // Entries that remain once this cycle's result leaves.
    assign count_shifted = count_reg - {1'b0, pop};
    assign byte_stall    = (count_shifted > 2'd1);
    assign accept        = byte_valid && !byte_stall;

    // Builds one result at the given position.
    function automatic cp_item_t make_result(
        input logic [CP_W-1:0]     cp,
        input status_t             st,
        input logic [OFFSET_W-1:0] start,
        input logic [LINE_W-1:0]   ln,
        input logic [COLUMN_W-1:0] col
    );
        cp_item_t r;
        r.codepoint     = cp;
        r.status        = st;
        r.line_number   = ln;
        r.column_number = col;
        r.start_offset  = start;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Decode of the offered byte against the current state.
    always_comb
    begin
        logic [7:0]          b;
        logic [CP_W-1:0]     gathered;
        logic [1:0]          left;
        logic [LINE_W-1:0]   ln;
        logic [COLUMN_W-1:0] col;
        logic                is_cont;
        cp_item_t            r;

        b       = byte_item.data_byte;
        is_cont = (b[7:6] == 2'b10);
        ln      = line_reg;
        col     = column_reg;

        pending_next   = pending_reg;
        partial_next   = partial_reg;
        counter_next   = counter_reg;
        seq_start_next = seq_start_reg;
        ended_next     = ended_reg;
        num_res        = 2'd0;
        res[0]         = make_result('0, ST_OK, '0, ln, col);
        res[1]         = res[0];
        r              = res[0];
        gathered       = {partial_reg[CP_W-7:0], b[5:0]};
        left           = pending_reg - 2'd1;

        if (byte_item.req_type == REQ_END)
        begin
            if (pending_reg != 2'd0)
            begin
                res[0] = make_result(REPLACEMENT_CP, ST_MALFORMED, seq_start_reg, ln, col);
                if (col != COLUMN_MAX)
                    col = col + 1'b1;
                num_res = 2'd1;
            end
            r = make_result('0, ST_END, counter_reg, ln, col);
            if (num_res == 2'd0)
                res[0] = r;
            else
                res[1] = r;
            num_res      = num_res + 2'd1;
            pending_next = 2'd0;
            partial_next = '0;
            ended_next   = 1'b1;
        end
        else if (!ended_reg)
        begin
            counter_next = counter_reg + 1'b1;
            if (pending_reg != 2'd0 && is_cont)
            begin
                pending_next = left;
                if (left == 2'd0)
                begin
                    res[0] = make_result(gathered, ST_OK, seq_start_reg, ln, col);
                    if (gathered == NEWLINE_CP)
                    begin
                        if (ln != LINE_MAX)
                            ln = ln + 1'b1;
                        col = COLUMN_W'(1);
                    end
                    else if (col != COLUMN_MAX)
                        col = col + 1'b1;
                    num_res      = 2'd1;
                    partial_next = '0;
                end
                else
                    partial_next = gathered;
            end
            else
            begin
                if (pending_reg != 2'd0)
                begin
                    res[0] = make_result(REPLACEMENT_CP, ST_MALFORMED, seq_start_reg, ln, col);
                    if (col != COLUMN_MAX)
                        col = col + 1'b1;
                    num_res      = 2'd1;
                    pending_next = 2'd0;
                    partial_next = '0;
                end
                // The byte now starts a new sequence.
                r = make_result(REPLACEMENT_CP, ST_BAD_LEAD, counter_reg, ln, col);
                priority if (b[7] == 1'b0)
                    r = make_result({{(CP_W-8){1'b0}}, b}, ST_OK, counter_reg, ln, col);
                else if (is_cont)
                    r.status = ST_MALFORMED;
                else if (b[7:5] == 3'b110)
                begin
                    partial_next   = {{(CP_W-5){1'b0}}, b[4:0]};
                    pending_next   = 2'd1;
                    seq_start_next = counter_reg;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial_next   = {{(CP_W-4){1'b0}}, b[3:0]};
                    pending_next   = 2'd2;
                    seq_start_next = counter_reg;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial_next   = {{(CP_W-3){1'b0}}, b[2:0]};
                    pending_next   = 2'd3;
                    seq_start_next = counter_reg;
                end
                else
                    r.status = ST_BAD_LEAD;

                if (b[7] == 1'b0 || is_cont || b[7:3] == 5'b11111)
                begin
                    if (num_res == 2'd0)
                        res[0] = r;
                    else
                        res[1] = r;
                    if (r.status == ST_OK && r.codepoint == NEWLINE_CP)
                    begin
                        if (ln != LINE_MAX)
                            ln = ln + 1'b1;
                        col = COLUMN_W'(1);
                    end
                    else if (col != COLUMN_MAX)
                        col = col + 1'b1;
                    num_res = num_res + 2'd1;
                end
            end
        end

        if (num_res == 2'd2)
            res[1].last_of_run = 1'b1;
        else
            res[0].last_of_run = 1'b1;

        line_next   = ln;
        column_next = col;
    end

    // Queue: drop the delivered entry, then append this byte's results.
    always_comb
    begin
        logic [1:0] slot;

        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (pop)
                queue_next[i] = queue_reg[i + 1];
            else
                queue_next[i] = queue_reg[i];
        end
        queue_next[QUEUE_DEPTH - 1] = queue_reg[QUEUE_DEPTH - 1];
        count_next = count_shifted;
        slot       = count_shifted;
        if (accept && num_res != 2'd0)
        begin
            queue_next[slot] = res[0];
            if (num_res == 2'd2)
                queue_next[slot + 2'd1] = res[1];
            count_next = count_shifted + num_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            counter_reg   <= '0;
            seq_start_reg <= '0;
            line_reg      <= LINE_W'(1);
            column_reg    <= COLUMN_W'(1);
            ended_reg     <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                pending_reg   <= pending_next;
                partial_reg   <= partial_next;
                counter_reg   <= counter_next;
                seq_start_reg <= seq_start_next;
                line_reg      <= line_next;
                column_reg    <= column_next;
                ended_reg     <= ended_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            queue_reg[i] <= queue_next[i];
    end

endmodule

`default_nettype wire

// File: tb/tb_utf8_decode_with_position_core.sv
// Self-checking regression for the UTF-8 decoder that tags codepoints with line, column and offset.
`timescale 1ns / 1ps

// The bench drives source bytes into the byte channel and keeps its own model of
// the decoder. Each byte item that the block accepts is run through that model,
// and the codepoint items it yields go onto a queue of expected codepoints. Every
// codepoint item that the block hands out is compared field by field with the
// oldest entry of that queue.
//
// Both sides idle at random. The sender may idle before each byte item, and
// the sink may hold stall high before each codepoint item. Stretches with no
// idling on one or both sides are mixed in.
//
// The tests run in this order:
//   - plain ASCII and newlines, with the extremes of the one-byte range;
//   - well-formed two-, three- and four-byte sequences, with overlong forms,
//     surrogates and the largest four-byte value;
//   - stray continuation bytes;
//   - sequences cut short, where one byte can yield two codepoint items;
//   - lead bytes of 0xF8 and above;
//   - a line long enough to saturate the column counter;
//   - a long random stream, mostly well-formed with random content;
//   - end of input, which must come last. Once the input has ended the block
//     drops every data byte, and reset is applied only once per run.
module tb_utf8_decode_with_position_core;
    import utf8d_pkg::*;

    // A run fails if this many cycles pass in a row with no item accepted on
    // either channel. The slowest correct run never comes near this number, since
    // each side only idles for a bounded random stretch before each item.
    localparam int STUCK_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1000;
    localparam int MAX_REPORTS = 10;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_item;
    logic       cp_valid;
    logic       cp_stall;
    cp_item_t   cp_item;

    // Idle controls. The tests switch them on and off.
    bit byte_idle_on;
    bit cp_idle_on;

    // Model of the decoder state.
    logic [1:0]          pend_cnt;
    logic [CP_W-1:0]     accum;
    logic [OFFSET_W-1:0] next_offset;
    logic [OFFSET_W-1:0] seq_offset;
    logic [LINE_W-1:0]   line_pos;
    logic [COLUMN_W-1:0] col_pos;
    bit                  ended;

    // Codepoint items that the model predicts, oldest first.
    cp_item_t expected_cps[$];

    int failures;
    int bytes_taken;
    int cps_checked;
    int status_hits[4];
    int stuck_cycles;

    utf8_decode_with_position_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_item    (cp_item)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic string fmt_cp(cp_item_t c);
        return $sformatf("cp=%06h status=%0d line=%0d col=%0d offset=%0d last=%0b",
                         c.codepoint, c.status, c.line_number, c.column_number,
                         c.start_offset, c.last_of_run);
    endfunction

    // Only the first few failures are printed in full; the rest are counted.
    function automatic void note_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endfunction

    // Queue one predicted codepoint item and move the position on. The end
    // item reports the position but does not consume a column. A newline
    // starts a new line at column 1. Both counters stop at their maximum.
    function automatic void add_cp(logic [CP_W-1:0] cp, status_t st,
                                   logic [OFFSET_W-1:0] off);
        cp_item_t c;
        c.codepoint     = cp;
        c.status        = st;
        c.line_number   = line_pos;
        c.column_number = col_pos;
        c.start_offset  = off;
        c.last_of_run   = 1'b0;
        expected_cps.push_back(c);
        if (st == ST_END)
        begin
            return;
        end
        if (st == ST_OK && cp == NEWLINE_CP)
        begin
            if (line_pos != LINE_MAX)
            begin
                line_pos = line_pos + 1'b1;
            end
            col_pos = COLUMN_W'(1);
        end
        else if (col_pos != COLUMN_MAX)
        begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // Treat b as the first byte of a new sequence. ASCII, stray continuation
    // and bad lead bytes give an item at once; a valid lead byte opens a
    // sequence and gives nothing yet.
    function automatic int open_sequence(logic [7:0] b, logic [OFFSET_W-1:0] off);
        if (b[7] == 1'b0)
        begin
            add_cp({13'd0, b}, ST_OK, off);
            return 1;
        end
        if (b[7:6] == 2'b10)
        begin
            add_cp(REPLACEMENT_CP, ST_MALFORMED, off);
            return 1;
        end
        if (b[7:5] == 3'b110)
        begin
            accum    = {16'd0, b[4:0]};
            pend_cnt = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            accum    = {17'd0, b[3:0]};
            pend_cnt = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            accum    = {18'd0, b[2:0]};
            pend_cnt = 2'd3;
        end
        else
        begin
            add_cp(REPLACEMENT_CP, ST_BAD_LEAD, off);
            return 1;
        end
        seq_offset = off;
        return 0;
    endfunction

    // Work out the codepoint items that one accepted byte item causes.
    function automatic void predict_item(byte_item_t it);
        int n;
        logic [OFFSET_W-1:0] off;
        n = 0;
        if (it.req_type == REQ_END)
        begin
            // A sequence still open at the end is flushed as a replacement.
            if (pend_cnt != 0)
            begin
                add_cp(REPLACEMENT_CP, ST_MALFORMED, seq_offset);
                n++;
                pend_cnt = 2'd0;
                accum    = '0;
            end
            add_cp('0, ST_END, next_offset);
            n++;
            ended = 1'b1;
        end
        else if (!ended)
        begin
            off         = next_offset;
            next_offset = off + 1'b1;
            if (pend_cnt != 0 && it.data_byte[7:6] == 2'b10)
            begin
                accum    = {accum[CP_W-7:0], it.data_byte[5:0]};
                pend_cnt = pend_cnt - 1'b1;
                if (pend_cnt == 0)
                begin
                    add_cp(accum, ST_OK, seq_offset);
                    n++;
                    accum = '0;
                end
            end
            else
            begin
                // A continuation byte was missing: the open sequence is
                // replaced and this byte starts over as a lead byte.
                if (pend_cnt != 0)
                begin
                    add_cp(REPLACEMENT_CP, ST_MALFORMED, seq_offset);
                    n++;
                    pend_cnt = 2'd0;
                    accum    = '0;
                end
                n += open_sequence(it.data_byte, off);
            end
        end
        if (n > 0)
        begin
            expected_cps[expected_cps.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function automatic void check_cp(cp_item_t got);
        cp_item_t want;
        cps_checked++;
        status_hits[got.status]++;
        if (expected_cps.size() == 0)
        begin
            note_failure($sformatf("codepoint item with none expected: %s", fmt_cp(got)));
            return;
        end
        want = expected_cps.pop_front();
        if (got.codepoint !== want.codepoint || got.status !== want.status ||
            got.line_number !== want.line_number ||
            got.column_number !== want.column_number ||
            got.start_offset !== want.start_offset ||
            got.last_of_run !== want.last_of_run)
        begin
            note_failure($sformatf("codepoint item %0d\n  expected %s\n  actual   %s",
                                   cps_checked, fmt_cp(want), fmt_cp(got)));
        end
    endfunction

    // Both channels are sampled at the rising edge, where the tester's inputs
    // have been stable since the falling edge. Results of a byte never appear
    // at the edge that accepts it, so checking before predicting is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cp_valid === 1'b1 && cp_stall === 1'b0)
            begin
                check_cp(cp_item);
            end
            if (byte_valid === 1'b1 && byte_stall === 1'b0)
            begin
                bytes_taken++;
                predict_item(byte_item);
            end
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (cp_valid && !cp_stall))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles + 1 >= STUCK_LIMIT)
            begin
                $display("Timeout: no item accepted for %0d cycles, %0d codepoint items outstanding",
                         STUCK_LIMIT, expected_cps.size());
                $display("utf8_decode_with_position_core regression: fail");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Codepoint sink. Before each item it draws a number of cycles to stall,
    // then keeps stall low until the item has been taken.
    initial
    begin
        int hold;
        cp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = cp_idle_on ? $urandom_range(0, 11) : 0;
            @(negedge clk);
            if (hold > 0)
            begin
                cp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            cp_stall <= 1'b0;
            @(posedge clk);
            while (cp_valid !== 1'b1)
            begin
                @(posedge clk);
            end
        end
    end

    // Send one byte item and return once the block has accepted it. The item
    // is driven at a falling edge and held until an edge with stall low.
    task automatic send_byte(req_t req, logic [7:0] b);
        int gap;
        byte_item_t it;
        gap          = byte_idle_on ? $urandom_range(0, 11) : 0;
        it.req_type  = req;
        it.data_byte = b;
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_data(logic [7:0] b);
        send_byte(REQ_DATA, b);
    endtask

    // One-byte range: NUL, printable, DEL, and newlines back to back.
    task automatic test_ascii_and_newlines();
        send_data(8'h00);
        send_data(8'h41);
        send_data(8'h7F);
        send_data(8'h0A);
        send_data(8'h0A);
        send_data(8'h20);
    endtask

    // Well-formed sequences of each length, including the largest four-byte
    // value, an overlong encoding of NUL and a surrogate, which all pass.
    task automatic test_multibyte();
        send_data(8'hC2); send_data(8'hA9);
        send_data(8'hE2); send_data(8'h82); send_data(8'hAC);
        send_data(8'hF0); send_data(8'h9F); send_data(8'h98); send_data(8'h80);
        send_data(8'hF7); send_data(8'hBF); send_data(8'hBF); send_data(8'hBF);
        send_data(8'hC0); send_data(8'h80);
        send_data(8'hED); send_data(8'hA0); send_data(8'h80);
    endtask

    task automatic test_stray_continuation();
        send_data(8'h80);
        send_data(8'hBF);
    endtask

    // A cut-short sequence followed by ASCII, a newline, a fresh lead byte,
    // or a bad lead byte. All but the fresh lead byte give two items from one byte.
    task automatic test_missing_continuation();
        send_data(8'hE2); send_data(8'h82); send_data(8'h41);
        send_data(8'hC3); send_data(8'h0A);
        send_data(8'hF0); send_data(8'hC3); send_data(8'hA9);
        send_data(8'hE1); send_data(8'hF8);
    endtask

    task automatic test_bad_lead();
        send_data(8'hF8);
        send_data(8'hFC);
        send_data(8'hFF);
    endtask

    // A single line long enough that the column counter saturates, then a
    // newline that brings it back to column 1. No idling, to keep it short.
    task automatic test_column_saturation();
        byte_idle_on = 1'b0;
        cp_idle_on   = 1'b0;
        repeat (int'(COLUMN_MAX) + 8)
        begin
            send_data(8'h61);
        end
        send_data(8'h0A);
        send_data(8'h62);
    endtask

    // Lead byte of a sequence of len bytes with random payload bits.
    function automatic logic [7:0] random_lead(int len);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        case (len)
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic logic [7:0] random_cont();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        return {2'b10, r[5:0]};
    endfunction

    // Mostly well-formed text with random content, plus cut-short sequences
    // and raw noise. The idle pattern changes every hundred bytes or so.
    task automatic test_random_stream();
        int sent;
        int next_switch;
        int kind;
        int len;
        int keep;
        int mode;
        logic [7:0] b;
        sent        = 0;
        next_switch = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (sent >= next_switch)
            begin
                mode         = $urandom_range(0, 3);
                byte_idle_on = mode[0];
                cp_idle_on   = mode[1];
                next_switch  = sent + $urandom_range(60, 140);
            end
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                b = ($urandom_range(0, 7) == 0) ? 8'h0A : 8'($urandom_range(0, 127));
                send_data(b);
                sent++;
            end
            else if (kind < 75)
            begin
                len = $urandom_range(2, 4);
                send_data(random_lead(len));
                repeat (len - 1)
                begin
                    send_data(random_cont());
                end
                sent += len;
            end
            else if (kind < 88)
            begin
                len  = $urandom_range(2, 4);
                keep = $urandom_range(0, len - 2);
                send_data(random_lead(len));
                repeat (keep)
                begin
                    send_data(random_cont());
                end
                // The interrupting byte must not be a continuation byte.
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                begin
                    b = b ^ 8'h40;
                end
                send_data(b);
                sent += keep + 2;
            end
            else
            begin
                send_data(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // End of input with a sequence still open: the flush comes first, then
    // the end item. Later data bytes are dropped and each end repeats.
    task automatic test_end_of_input();
        byte_idle_on = 1'b1;
        cp_idle_on   = 1'b1;
        send_data(8'hE2);
        send_data(8'h82);
        send_byte(REQ_END, 8'hFF);
        send_data(8'h41);
        send_data(8'hC2);
        send_byte(REQ_END, 8'h00);
        send_data(8'h0A);
        send_byte(REQ_END, 8'h5A);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_item    = '0;
        byte_idle_on = 1'b1;
        cp_idle_on   = 1'b1;
        failures     = 0;
        bytes_taken  = 0;
        cps_checked  = 0;
        stuck_cycles = 0;
        status_hits  = '{default: 0};
        pend_cnt     = '0;
        accum        = '0;
        next_offset  = '0;
        seq_offset   = '0;
        line_pos     = LINE_W'(1);
        col_pos      = COLUMN_W'(1);
        ended        = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ascii_and_newlines();
        test_multibyte();
        test_stray_continuation();
        test_missing_continuation();
        test_bad_lead();
        test_column_saturation();
        test_random_stream();
        test_end_of_input();

        @(negedge clk);
        byte_valid <= 1'b0;
        // Let the block drain; the watchdog catches a block that never does.
        while (expected_cps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Covered %0d byte items and %0d codepoint items.", bytes_taken, cps_checked);
        $display("By status: %0d ok, %0d malformed, %0d bad lead, %0d end; %0d mismatches.",
                 status_hits[ST_OK], status_hits[ST_MALFORMED], status_hits[ST_BAD_LEAD],
                 status_hits[ST_END], failures);
        if (failures == 0)
        begin
            $display("utf8_decode_with_position_core regression: pass");
        end
        else
        begin
            $display("utf8_decode_with_position_core regression: fail");
        end
        $finish;
    end

endmodule
